### hdl/assert_macros.svh
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset
`define ASSERT_AT(label, clk_sig, rstn_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
        else $error("sequencer assertion failed");

// Same, on the usual clk and rst_n
`define ASSERT_DEF(label, prop) `ASSERT_AT(label, clk, rst_n, prop)

`endif

### hdl/tss_pkg.sv
`default_nettype none

package tss_pkg;

    // Table geometry and jump limit
    localparam int TABLE_DEPTH = 256;
    localparam int MAX_JUMPS   = 16;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int JCNT_W = $clog2(MAX_JUMPS + 1);

    localparam logic [IDX_W:0]    DEPTH_X    = (IDX_W + 1)'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [16:0]       ADDR_LIMIT = 17'(TABLE_DEPTH);
    localparam logic [JCNT_W-1:0] MAX_J      = JCNT_W'(MAX_JUMPS);

    // Opcodes
    localparam logic [7:0] OP_END  = 8'h00;
    localparam logic [7:0] OP_JUMP = 8'hD0;

    localparam logic [7:0] ELAPSED_MAX = 8'hFF;

    // Signed jump offset byte reduced modulo the table depth
    typedef logic [IDX_W-1:0] off_tab_t [256];

    function automatic off_tab_t build_off_tab();
        off_tab_t t;
        int       s;
        for (int k = 0; k < 256; k++)
        begin
            s    = (k < 128) ? k : k - 256;
            t[k] = IDX_W'((s + 256 * TABLE_DEPTH) % TABLE_DEPTH);
        end
        return t;
    endfunction

    localparam off_tab_t OFF_MOD = build_off_tab();

endpackage

`default_nettype wire

### hdl/timed_step_sequencer.sv
`default_nettype none

// Table-driven timed sequencer. An input transfer with s_tuser = 0 writes one table
// entry (duration byte, opcode byte); its result is loaded into the output register from
// S_OUT, and the next input transfer is taken once the block is back in S_IDLE.
// A transfer with s_tuser = 1 is one tick: the entry at the current index is read from
// the table RAM, relative jumps (opcode 0xD0) are followed one table read at a time, and
// the entry reached is reported. A tick passes through S_READ, S_EVAL and S_OUT before
// its result is loaded, and the next input transfer is taken back in S_IDLE. Each jump
// taken adds one more S_READ and S_EVAL (one RAM read and one evaluation step). Either
// kind also waits in S_OUT while the output register still holds an earlier result that
// m_tready has not taken. The RAM read latency and the jump loop through the single read
// port set this sequence of states. Entries must be written before a tick reads them.
// hold_at_end is written through cfg_wr_en / cfg_wr_data.
module timed_step_sequencer
    import tss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,   // hold_at_end
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,       // entry_address, entry_duration, entry_opcode
    input  wire logic [0:0]  s_tuser,       // func
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,       // step_duration, step_opcode
    output logic      [3:0]  m_tuser        // step_valid, finished, restarted, jump_limit_hit
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [7:0] dur;
        logic [7:0] op;
        logic       limit;
        logic       restarted;
        logic       finished;
        logic       valid;
    } result_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [7:0]        elapsed_reg, elapsed_next;
    logic              finished_reg, finished_next;
    logic              hold_reg, hold_next;
    logic [JCNT_W-1:0] jumps_reg, jumps_next;
    result_t           res_reg, res_next;
    result_t           out_reg, out_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic              in_xfer;
    logic              out_xfer;
    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [15:0]       ram_rd_data;
    logic [7:0]        dur_b;
    logic [7:0]        op_b;
    logic [IDX_W:0]    jump_sum;
    logic [IDX_W-1:0]  jump_idx;
    logic [IDX_W-1:0]  inc_idx;
    logic [7:0]        elapsed_inc;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid_reg && m_tready;

    // Table writes go straight to the RAM on the input transfer
    assign ram_wr_en = in_xfer && !s_tuser[0] && ({9'd0, s_tdata[7:0]} < ADDR_LIMIT);
    assign ram_rd_en = (state_reg == S_READ);

    tss_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (IDX_W'(s_tdata[7:0])),
        .wr_data ({s_tdata[23:16], s_tdata[15:8]}),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    // Entry fields and index arithmetic
    assign dur_b    = ram_rd_data[7:0];
    assign op_b     = ram_rd_data[15:8];
    assign jump_sum = {1'b0, idx_reg} + {1'b0, OFF_MOD[dur_b]};
    assign jump_idx = (jump_sum >= DEPTH_X) ? IDX_W'(jump_sum - DEPTH_X) : jump_sum[IDX_W-1:0];
    assign inc_idx  = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? ELAPSED_MAX : elapsed_reg + 8'd1;

    // Sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        elapsed_next  = elapsed_reg;
        finished_next = finished_reg;
        hold_next     = cfg_wr_en ? cfg_wr_data : hold_reg;
        jumps_next    = jumps_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        m_tvalid_next = out_xfer ? 1'b0 : m_tvalid_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    jumps_next = '0;
                    if (s_tuser[0])
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        res_next          = '0;
                        res_next.finished = finished_reg;
                        state_next        = S_OUT;
                    end
                end
            end

            S_READ:
            begin
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                res_next.dur       = dur_b;
                res_next.op        = op_b;
                res_next.valid     = 1'b0;
                res_next.restarted = 1'b0;
                res_next.limit     = 1'b0;
                res_next.finished  = finished_reg;
                state_next         = S_OUT;
                case (op_b)
                    OP_JUMP:
                    begin
                        if (jumps_reg >= MAX_J)
                        begin
                            res_next.limit = 1'b1;
                        end
                        else
                        begin
                            jumps_next   = jumps_reg + 1'b1;
                            elapsed_next = '0;
                            idx_next     = jump_idx;
                            state_next   = S_READ;
                        end
                    end
                    OP_END:
                    begin
                        if (hold_reg)
                        begin
                            finished_next     = 1'b1;
                            res_next.finished = 1'b1;
                        end
                        else
                        begin
                            idx_next           = '0;
                            finished_next      = 1'b0;
                            res_next.finished  = 1'b0;
                            res_next.restarted = 1'b1;
                        end
                    end
                    default:
                    begin
                        // timed step: negative duration advances at once
                        res_next.valid = 1'b1;
                        if (dur_b[7])
                        begin
                            elapsed_next = '0;
                            idx_next     = inc_idx;
                        end
                        else if (elapsed_inc >= dur_b)
                        begin
                            elapsed_next = '0;
                            idx_next     = inc_idx;
                        end
                        else
                        begin
                            elapsed_next = elapsed_inc;
                        end
                    end
                endcase
            end

            S_OUT:
            begin
                // load output register once it is free
                if (!m_tvalid_reg || m_tready)
                begin
                    out_next      = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            elapsed_reg  <= '0;
            finished_reg <= 1'b0;
            hold_reg     <= 1'b0;
            jumps_reg    <= '0;
            res_reg      <= '0;
            out_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            elapsed_reg  <= elapsed_next;
            finished_reg <= finished_next;
            hold_reg     <= hold_next;
            jumps_reg    <= jumps_next;
            res_reg      <= res_next;
            out_reg      <= out_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.op, out_reg.dur};
    assign m_tuser  = {out_reg.limit, out_reg.restarted, out_reg.finished, out_reg.valid};

endmodule

`default_nettype wire

### hdl/tss_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module tss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/tss_checker.sv
`default_nettype none

`include "assert_macros.svh"

// Port-level checks on the sequencer output stream
module tss_checker
    import tss_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [3:0]  m_tuser
);

    logic       stalled;
    logic [7:0] out_op;

    assign stalled = m_tvalid && !m_tready;
    assign out_op  = m_tdata[15:8];

    // stalled result holds until transfer
    `ASSERT_DEF(a_out_hold, stalled |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // a restart clears finished and reports no step
    `ASSERT_DEF(a_restart_clean, m_tvalid && m_tuser[2] |-> m_tuser[1:0] == 2'b00 && !m_tuser[3])

    // jump limit shows the jump entry and no step
    `ASSERT_DEF(a_limit_on_jump, m_tvalid && m_tuser[3] |-> out_op == OP_JUMP && !m_tuser[0])

    // a presented step is never an end or a jump entry
    `ASSERT_DEF(a_step_opcode, m_tvalid && m_tuser[0] |-> out_op != OP_END && out_op != OP_JUMP)

endmodule

bind timed_step_sequencer tss_checker u_tss_checker (.*);

`default_nettype wire
